// File: hw/rtl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared constants and types of the five-point laplacian stencil block:
// grid limits, arithmetic widths, register indexes and inter-module structs.
// ----------------------------------------------------------------------------
package lps_pkg;

  // grid and data geometry
  localparam int MAX_COLS  = 1024;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int NCOL_W    = 11;
  localparam int ROW_W     = 16;
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;

  // stencil arithmetic widths
  localparam int SUM_W     = DATA_W + 3;
  localparam int LO_W      = 17;
  localparam int HI_W      = SUM_W - LO_W;
  localparam int PHI_W     = DATA_W + HI_W;
  localparam int PLO_W     = DATA_W + LO_W + 1;
  localparam int T_W       = DATA_W + SUM_W - FRAC_W;
  localparam int ACC_W     = T_W + 1;

  // output queue
  localparam int OQ_DEPTH  = 16;
  localparam int OQ_AW     = $clog2(OQ_DEPTH);
  localparam int CNT_W     = $clog2(OQ_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;

  // register reset values and grid clamps
  localparam logic [ROW_W-1:0]  NUM_ROWS_RST = ROW_W'(3);
  localparam logic [NCOL_W-1:0] NUM_COLS_RST = NCOL_W'(3);
  localparam logic [DATA_W-1:0] SCALE_RST    = DATA_W'(65536);
  localparam logic [ROW_W-1:0]  NR_MIN       = ROW_W'(3);
  localparam logic [NCOL_W-1:0] NC_MIN       = NCOL_W'(3);
  localparam logic [NCOL_W-1:0] NC_MAX       = NCOL_W'(MAX_COLS);

  // line buffer access issued at accept
  typedef struct packed {
    logic              vld;
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] smp;
    logic [DATA_W-1:0] acc;
  } lb_req_t;

  // line buffer read data, valid in the cycle after accept
  typedef struct packed {
    logic [DATA_W-1:0] centre;
    logic [DATA_W-1:0] right;
    logic [DATA_W-1:0] up;
    logic [DATA_W-1:0] accum;
    logic [DATA_W-1:0] left;
  } lb_rsp_t;

  // per-item control carried down the arithmetic pipe
  typedef struct packed {
    logic             vld;
    logic             has_b;
    logic             interior;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } item_meta_t;

  // one result transaction
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              last;
  } out_item_t;

  // up to two results pushed per cycle
  typedef struct packed {
    logic      vld0;
    logic      vld1;
    out_item_t item0;
    out_item_t item1;
  } oq_push_t;

endpackage

// File: hw/rtl/lps_linebuf.sv
// ----------------------------------------------------------------------------
// lps_linebuf
// Line buffers: previous-row samples (two read ports) and a combined
// row-before-previous / previous-row accumulator memory, with write-back
// forwarding and the left neighbour register.
// ----------------------------------------------------------------------------
module lps_linebuf import lps_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  lb_req_t req,
  output lb_rsp_t rsp
);

  logic [DATA_W-1:0]   smp_mem [MAX_COLS];
  logic [2*DATA_W-1:0] hist_mem [MAX_COLS];

  logic [DATA_W-1:0]   centre_r;
  logic [DATA_W-1:0]   right_r;
  logic [2*DATA_W-1:0] hist_rd_r;
  logic [2*DATA_W-1:0] fwd_data_r;
  logic                fwd_r;
  logic                wb_vld_r;
  logic [COL_W-1:0]    wb_col_r;
  logic [DATA_W-1:0]   wb_acc_r;
  logic [DATA_W-1:0]   left_r;

  logic [COL_W-1:0]    right_addr;
  logic [2*DATA_W-1:0] hist_wdata;
  logic [2*DATA_W-1:0] hist_q;

  assign right_addr = req.col + COL_W'(1);
  assign hist_wdata = {centre_r, wb_acc_r};

  // sample row memory, read-first so the old sample comes back
  always_ff @(posedge clk) begin
    if (req.vld) begin
      smp_mem[req.col] <= req.smp;
      centre_r         <= smp_mem[req.col];
      right_r          <= smp_mem[right_addr];
    end
  end

  // history memory: old sample becomes row-before-previous, with accumulator
  always_ff @(posedge clk) begin
    if (wb_vld_r) begin
      hist_mem[wb_col_r] <= hist_wdata;
    end
    if (req.vld) begin
      hist_rd_r  <= hist_mem[req.col];
      fwd_data_r <= hist_wdata;
    end
  end

  // write-back stage control and left neighbour
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
      left_r   <= '0;
    end else begin
      wb_vld_r <= req.vld;
      if (req.vld) begin
        fwd_r <= wb_vld_r && (wb_col_r == req.col);
      end
      if (wb_vld_r) begin
        left_r <= centre_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.vld) begin
      wb_col_r <= req.col;
      wb_acc_r <= req.acc;
    end
  end

  // read data with forwarding of a same-cycle write-back
  assign hist_q     = fwd_r ? fwd_data_r : hist_rd_r;
  assign rsp.centre = centre_r;
  assign rsp.right  = right_r;
  assign rsp.up     = hist_q[2*DATA_W-1:DATA_W];
  assign rsp.accum  = hist_q[DATA_W-1:0];
  assign rsp.left   = left_r;

endmodule

// File: hw/rtl/lps_stencil.sv
// ----------------------------------------------------------------------------
// lps_stencil
// Arithmetic pipe: stencil sum, split scale multiply, Q16.16 shift,
// accumulate and saturate. Boundary points give zero.
// ----------------------------------------------------------------------------
module lps_stencil import lps_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [DATA_W-1:0] scale,
  input  item_meta_t               meta_in,
  input  lb_rsp_t                  rsp,
  input  logic [DATA_W-1:0]        down,
  output item_meta_t               meta_out,
  output logic [DATA_W-1:0]        value_out
);

  logic signed [SUM_W-1:0]  sum_b;
  item_meta_t               c_meta_r;
  logic signed [SUM_W-1:0]  c_sum_r;
  logic signed [DATA_W-1:0] c_acc_r;

  logic signed [PHI_W-1:0]  p_hi;
  logic signed [PLO_W-1:0]  p_lo;
  item_meta_t               d_meta_r;
  logic signed [PHI_W-1:0]  d_hi_r;
  logic signed [PLO_W-1:0]  d_lo_r;
  logic signed [DATA_W-1:0] d_acc_r;

  logic signed [PLO_W-1:0]  lo_sh;
  logic signed [T_W-1:0]    t_d;
  item_meta_t               e_meta_r;
  logic signed [T_W-1:0]    e_t_r;
  logic signed [DATA_W-1:0] e_acc_r;

  logic signed [ACC_W-1:0]  total;
  logic [DATA_W-1:0]        sat_val;
  item_meta_t               f_meta_r;
  logic [DATA_W-1:0]        f_value_r;

  // four times centre minus the four neighbours, exact
  assign sum_b = (SUM_W'($signed(rsp.centre)) <<< 2)
               - SUM_W'($signed(rsp.up))
               - SUM_W'($signed(down))
               - SUM_W'($signed(rsp.left))
               - SUM_W'($signed(rsp.right));

  // partial products of scale times sum
  assign p_hi = scale * $signed(c_sum_r[SUM_W-1:LO_W]);
  assign p_lo = scale * $signed({1'b0, c_sum_r[LO_W-1:0]});

  // floor of product over 2^16: hi part is an exact multiple of 2^17
  assign lo_sh = d_lo_r >>> FRAC_W;
  assign t_d   = (T_W'(d_hi_r) <<< 1) + T_W'(lo_sh);

  // accumulate and saturate to data width
  assign total = ACC_W'(e_t_r) + ACC_W'(e_acc_r);

  always_comb begin
    if ((total[ACC_W-1:DATA_W-1] == '0) || (total[ACC_W-1:DATA_W-1] == '1)) begin
      sat_val = total[DATA_W-1:0];
    end else if (total[ACC_W-1]) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // pipe valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_meta_r.vld <= 1'b0;
      d_meta_r.vld <= 1'b0;
      e_meta_r.vld <= 1'b0;
      f_meta_r.vld <= 1'b0;
    end else begin
      c_meta_r.vld <= meta_in.vld;
      d_meta_r.vld <= c_meta_r.vld;
      e_meta_r.vld <= d_meta_r.vld;
      f_meta_r.vld <= e_meta_r.vld;
    end
  end

  // pipe payload
  always_ff @(posedge clk) begin
    c_meta_r.has_b    <= meta_in.has_b;
    c_meta_r.interior <= meta_in.interior;
    c_meta_r.last     <= meta_in.last;
    c_meta_r.row      <= meta_in.row;
    c_meta_r.col      <= meta_in.col;
    c_sum_r           <= sum_b;
    c_acc_r           <= $signed(rsp.accum);

    d_meta_r.has_b    <= c_meta_r.has_b;
    d_meta_r.interior <= c_meta_r.interior;
    d_meta_r.last     <= c_meta_r.last;
    d_meta_r.row      <= c_meta_r.row;
    d_meta_r.col      <= c_meta_r.col;
    d_hi_r            <= p_hi;
    d_lo_r            <= p_lo;
    d_acc_r           <= c_acc_r;

    e_meta_r.has_b    <= d_meta_r.has_b;
    e_meta_r.interior <= d_meta_r.interior;
    e_meta_r.last     <= d_meta_r.last;
    e_meta_r.row      <= d_meta_r.row;
    e_meta_r.col      <= d_meta_r.col;
    e_t_r             <= t_d;
    e_acc_r           <= d_acc_r;

    f_meta_r.has_b    <= e_meta_r.has_b;
    f_meta_r.interior <= e_meta_r.interior;
    f_meta_r.last     <= e_meta_r.last;
    f_meta_r.row      <= e_meta_r.row;
    f_meta_r.col      <= e_meta_r.col;
    f_value_r         <= e_meta_r.interior ? sat_val : '0;
  end

  assign meta_out  = f_meta_r;
  assign value_out = f_value_r;

endmodule

// File: hw/rtl/lps_outq.sv
// ----------------------------------------------------------------------------
// lps_outq
// Result queue: takes up to two results per cycle, hands out one per
// transaction. Space is reserved by the top level before an item is taken.
// ----------------------------------------------------------------------------
module lps_outq import lps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  oq_push_t  push,
  input  logic      pop,
  output logic      head_vld,
  output out_item_t head
);

  out_item_t        q_mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wptr_r;
  logic [OQ_AW-1:0] rptr_r;
  logic [CNT_W-1:0] count_r;
  logic [OQ_AW-1:0] wptr_p1;
  logic [OQ_AW-1:0] wptr_nxt;
  logic [CNT_W-1:0] count_nxt;

  assign wptr_p1   = wptr_r + OQ_AW'(1);
  assign wptr_nxt  = wptr_r + OQ_AW'({push.vld0, 1'b0} == 2'b10 ? 1 : 0)
                            + OQ_AW'(push.vld1);
  assign count_nxt = count_r + CNT_W'(push.vld0) + CNT_W'(push.vld1) - CNT_W'(pop);

  // queue storage
  always_ff @(posedge clk) begin
    if (push.vld0) begin
      q_mem[wptr_r] <= push.item0;
    end
    if (push.vld1) begin
      q_mem[wptr_p1] <= push.item1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      count_r <= count_nxt;
      if (pop) begin
        rptr_r <= rptr_r + OQ_AW'(1);
      end
    end
  end

  assign head_vld = (count_r != '0);
  assign head     = q_mem[rptr_r];

endmodule

// File: hw/rtl/laplacian_5pt_stencil_apply.sv
// ----------------------------------------------------------------------------
// laplacian_5pt_stencil_apply
// Scaled five-point laplacian over a raster-streamed grid, Dirichlet boundary.
// ----------------------------------------------------------------------------
// Takes one grid point per cycle in raster order (column fastest) unless
// in_stall is high, and returns accumulate_in + scale * (4*centre -
// neighbours) for interior points, zero on the boundary, saturated Q16.16.
// Results lag one row behind their inputs; each point of the last row also
// returns its own zero result right after the result above it. Sustained
// rate is one point per cycle while one result per point comes out; in the
// last row two results per point leave through the one-per-cycle result
// port, so in_stall holds input back there.
// in_stall rises when the 16-entry result queue has no room left for two more
// results. The line buffers are two single-clock memories: 1024 x 32 previous
// row samples read at two addresses, and 1024 x 64 holding the row before it
// with the previous-row accumulators. They are not cleared after reset: a
// grid in progress must not be reshaped through num_rows or num_cols.
// ----------------------------------------------------------------------------
module laplacian_5pt_stencil_apply import lps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DATA_W-1:0]    in_sample,
  input  logic [DATA_W-1:0]    in_accumulate_in,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    out_value,
  output logic [ROW_W-1:0]     out_row,
  output logic [COL_W-1:0]     out_col,
  output logic                 out_last
);

  logic [ROW_W-1:0]  num_rows_r;
  logic [NCOL_W-1:0] num_cols_r;
  logic [DATA_W-1:0] scale_r;

  logic [ROW_W-1:0]  row_cnt_r;
  logic [ROW_W-1:0]  row_cnt_nxt;
  logic [COL_W-1:0]  col_cnt_r;
  logic [COL_W-1:0]  col_cnt_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;

  logic [ROW_W-1:0]  nr;
  logic [NCOL_W-1:0] nc_lo;
  logic [NCOL_W-1:0] nc;
  logic              restart;
  logic [ROW_W-1:0]  r;
  logic [COL_W-1:0]  c;
  logic              has_a;
  logic              has_b;
  logic              at_last_col;
  logic              interior;
  logic [NCOL_W-1:0] c_inc;
  logic [ROW_W:0]    r_inc;
  logic [1:0]        n_acc;
  logic              in_acc;
  logic              pop;

  lb_req_t           lb_req;
  lb_rsp_t           lb_rsp;
  item_meta_t        b_meta_r;
  logic [DATA_W-1:0] b_down_r;
  item_meta_t        res_meta;
  logic [DATA_W-1:0] res_value;
  oq_push_t          oq_push;
  out_item_t         oq_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= NUM_ROWS_RST;
      num_cols_r <= NUM_COLS_RST;
      scale_r    <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_ROWS: num_rows_r <= cfg_data[ROW_W-1:0];
        CFG_NUM_COLS: num_cols_r <= cfg_data[NCOL_W-1:0];
        CFG_SCALE:    scale_r    <= cfg_data;
        default:      ;
      endcase
    end
  end

  // effective grid size
  assign nr    = (num_rows_r < NR_MIN) ? NR_MIN : num_rows_r;
  assign nc_lo = (num_cols_r < NC_MIN) ? NC_MIN : num_cols_r;
  assign nc    = (nc_lo > NC_MAX) ? NC_MAX : nc_lo;

  // position of the incoming point, restarting if outside the grid
  assign restart = (row_cnt_r >= nr) || (NCOL_W'(col_cnt_r) >= nc);
  assign r       = restart ? '0 : row_cnt_r;
  assign c       = restart ? '0 : col_cnt_r;

  assign has_a       = (r != '0);
  assign has_b       = (r == nr - ROW_W'(1));
  assign at_last_col = (NCOL_W'(c) == nc - NCOL_W'(1));
  assign interior    = (r >= ROW_W'(2)) && (c != '0) && !at_last_col;
  assign n_acc       = {1'b0, has_a} + {1'b0, has_b};

  // raster counters
  assign c_inc = NCOL_W'(c) + NCOL_W'(1);
  assign r_inc = {1'b0, r} + (ROW_W+1)'(1);

  always_comb begin
    row_cnt_nxt = r;
    col_cnt_nxt = c_inc[COL_W-1:0];
    if (c_inc == nc) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (r_inc == {1'b0, nr}) ? '0 : r_inc[ROW_W-1:0];
    end
  end

  // handshake and result credit
  assign in_stall = (cnt_r > CNT_W'(OQ_DEPTH - 2));
  assign in_acc   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  assign cnt_nxt  = cnt_r + (in_acc ? CNT_W'(n_acc) : '0) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r    <= '0;
      col_cnt_r    <= '0;
      cnt_r        <= '0;
      b_meta_r.vld <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      b_meta_r.vld <= in_acc && has_a;
      if (in_acc) begin
        row_cnt_r <= row_cnt_nxt;
        col_cnt_r <= col_cnt_nxt;
      end
    end
  end

  // item control alongside the line buffer read
  always_ff @(posedge clk) begin
    b_meta_r.has_b    <= has_b;
    b_meta_r.interior <= interior;
    b_meta_r.last     <= at_last_col;
    b_meta_r.row      <= r;
    b_meta_r.col      <= c;
    b_down_r          <= in_sample;
  end

  assign lb_req.vld = in_acc;
  assign lb_req.col = c;
  assign lb_req.smp = in_sample;
  assign lb_req.acc = in_accumulate_in;

  lps_linebuf u_linebuf (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (lb_req),
    .rsp   (lb_rsp)
  );

  lps_stencil u_stencil (
    .clk       (clk),
    .rst_n     (rst_n),
    .scale     ($signed(scale_r)),
    .meta_in   (b_meta_r),
    .rsp       (lb_rsp),
    .down      (b_down_r),
    .meta_out  (res_meta),
    .value_out (res_value)
  );

  // result above the point, then the point's own zero in the last row
  assign oq_push.vld0        = res_meta.vld;
  assign oq_push.vld1        = res_meta.vld && res_meta.has_b;
  assign oq_push.item0.value = res_value;
  assign oq_push.item0.row   = res_meta.row - ROW_W'(1);
  assign oq_push.item0.col   = res_meta.col;
  assign oq_push.item0.last  = 1'b0;
  assign oq_push.item1.value = '0;
  assign oq_push.item1.row   = res_meta.row;
  assign oq_push.item1.col   = res_meta.col;
  assign oq_push.item1.last  = res_meta.last;

  lps_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (oq_push),
    .pop      (pop),
    .head_vld (out_valid),
    .head     (oq_head)
  );

  assign out_value = oq_head.value;
  assign out_row   = oq_head.row;
  assign out_col   = oq_head.col;
  assign out_last  = oq_head.last;

endmodule

// File: hw/rtl/lps_checker.sv
// ----------------------------------------------------------------------------
// lps_checker
// Port-level checks of the stencil block, bound to the top level.
// ----------------------------------------------------------------------------
module lps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_value,
  input logic [15:0] out_row,
  input logic [9:0]  out_col,
  input logic        out_last
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_row)
      && $stable(out_col) && $stable(out_last))
    else $error("stalled result changed or dropped");

  // nothing pending after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // first column is boundary
  a_col0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_col == 10'd0) |-> (out_value == 32'd0))
    else $error("nonzero result in first column");

  // first row is boundary
  a_row0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row == 16'd0) |-> (out_value == 32'd0))
    else $error("nonzero result in first row");

  // final grid point is a boundary corner
  a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_value == 32'd0) && (out_col != 10'd0))
    else $error("bad final result");

endmodule

bind laplacian_5pt_stencil_apply lps_checker u_lps_checker (.*);
